// ----- rtl/segi_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared word types, widths and orientation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package segi_pkg;

	localparam int CW    = 16;
	localparam int DIFW  = CW + 1;
	localparam int PRW   = 2 * DIFW;
	localparam int OW    = PRW + 1;
	localparam int DW    = PRW;
	localparam int CAW   = 2 * CW + 1;
	localparam int QB    = 33;
	localparam int OUT_W = 32;

	localparam logic [QB-1:0] LIM_POS = QB'(33'h0_7fff_ffff);
	localparam logic [QB-1:0] LIM_NEG = QB'(33'h0_8000_0000);
	localparam logic signed [OUT_W-1:0] SAT_MAX = 32'sh7fff_ffff;
	localparam logic signed [OUT_W-1:0] SAT_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		OR_COL = 2'd0,
		OR_CW  = 2'd1,
		OR_CCW = 2'd2
	} orient_t;

	typedef struct packed {
		logic signed [CW-1:0] a_start_x;
		logic signed [CW-1:0] a_start_y;
		logic signed [CW-1:0] a_end_x;
		logic signed [CW-1:0] a_end_y;
		logic signed [CW-1:0] b_start_x;
		logic signed [CW-1:0] b_start_y;
		logic signed [CW-1:0] b_end_x;
		logic signed [CW-1:0] b_end_y;
	} seg_in_t;

	typedef struct packed {
		logic                    intersects;
		logic                    parallel;
		logic signed [OUT_W-1:0] point_x;
		logic signed [OUT_W-1:0] point_y;
		logic                    saturated;
	} seg_out_t;

	function automatic orient_t orient_code(input logic signed [OW-1:0] v);
		orient_t o;
		if (v == '0) begin
			o = OR_COL;
		end else if (!v[OW-1]) begin
			o = OR_CW;
		end else begin
			o = OR_CCW;
		end
		return o;
	endfunction

	function automatic logic in_box(
		input logic signed [CW-1:0] px, py, qx, qy, rx, ry
	);
		logic signed [CW-1:0] xmax, xmin, ymax, ymin;
		xmax = (px > rx) ? px : rx;
		xmin = (px < rx) ? px : rx;
		ymax = (py > ry) ? py : ry;
		ymin = (py < ry) ? py : ry;
		return (qx <= xmax) && (qx >= xmin) && (qy <= ymax) && (qy >= ymin);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/segment_intersection_unit.sv -----
// ----------------------------------------------------------------------------
// Segment intersection unit
// Orientation test of two closed segments and the intersection point of
// their supporting lines in signed fixed point, as a deep pipeline.
// ----------------------------------------------------------------------------
//  channel   direction   handshake               word
//  seg       in          seg_valid / seg_ready   segi_pkg::seg_in_t
//  res       out         res_valid / res_ready   segi_pkg::seg_out_t
//
// One word enters per cycle while the pipeline is not stalled; a result
// passes through 41 register stages, the first loaded at the accepting edge, made of
// seven arithmetic stages, 33 restoring divider stages (one quotient bit
// each) and the output register. The divider stages set the latency.
// Reset clears only the valid bits. When the output word is not taken the
// whole pipeline holds and seg_ready falls.
`default_nettype none

module segment_intersection_unit #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               seg_valid,
	output logic                    seg_ready,
	input  wire segi_pkg::seg_in_t  seg,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output segi_pkg::seg_out_t      res
);
	import segi_pkg::*;

	localparam int NW = CAW + DIFW + 1;
	localparam int SW = NW + FRAC_BITS;

	typedef struct packed {
		logic                 hit;
		logic                 par;
		logic                 negx;
		logic                 negy;
		logic                 ovfx;
		logic                 ovfy;
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
	} side_t;

	typedef struct packed {
		logic [DW-1:0] rx;
		logic [DW-1:0] ry;
		logic [QB-1:0] lx;
		logic [QB-1:0] ly;
		logic [QB-1:0] qx;
		logic [QB-1:0] qy;
		logic [DW-1:0] d;
		side_t         sd;
	} div_t;

	logic en;

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [CW-1:0]   ax_s1, ay_s1, ex_s1, ey_s1, bx_s1, by_s1, fx_s1, fy_s1;
	logic signed [DIFW-1:0] dax_s1, day_s1, dbx_s1, dby_s1;
	logic signed [DIFW-1:0] ebx_s1, eby_s1, efx_s1, efy_s1, fax_s1, fay_s1;
	logic [3:0]             box_s1, box_s2, box_s3;

	logic signed [PRW-1:0]  p1a_s2, p1b_s2, p2a_s2, p2b_s2, p3a_s2, p3b_s2;
	logic signed [PRW-1:0]  p4a_s2, p4b_s2, pda_s2, pdb_s2;
	logic signed [2*CW-1:0] caa_s2, cab_s2, cba_s2, cbb_s2;
	logic signed [CW-1:0]   ax_s2, ay_s2, ax_s3, ay_s3, ax_s4, ay_s4, ax_s5, ay_s5;
	logic signed [DIFW-1:0] dax_s2, day_s2, dbx_s2, dby_s2;
	logic signed [DIFW-1:0] dax_s3, day_s3, dbx_s3, dby_s3;

	orient_t                o1_s3, o2_s3, o3_s3, o4_s3;
	logic signed [OW-1:0]   det_s3, det_s4, det_s5;
	logic signed [CAW-1:0]  ca_s3, cb_s3;

	logic                   hit_s4, hit_s5;
	logic signed [NW-1:0]   nxa_s4, nxb_s4, nya_s4, nyb_s4;
	logic signed [NW-1:0]   nx_s5, ny_s5;

	logic                   hit_s6, par_s6, negx_s6, negy_s6;
	logic [NW-1:0]          mx_s6, my_s6;
	logic [DW-1:0]          dm_s6;
	logic signed [CW-1:0]   ax_s6, ay_s6;

	logic [SW-1:0]          shx, shy;
	side_t                  sd0;

	div_t                   div_s [0:QB];
	logic                   dv_s  [0:QB];
	div_t                   nxt   [1:QB];

	div_t                   fin;
	logic                   satx, saty;
	logic signed [OUT_W-1:0] qpx, qpy;
	logic                   out_v_q;
	seg_out_t               out_q;

	assign en        = !out_v_q || res_ready;
	assign seg_ready = en;
	assign res_valid = out_v_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= seg_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			out_v_q <= dv_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= seg.a_start_x;
			ay_s1  <= seg.a_start_y;
			ex_s1  <= seg.a_end_x;
			ey_s1  <= seg.a_end_y;
			bx_s1  <= seg.b_start_x;
			by_s1  <= seg.b_start_y;
			fx_s1  <= seg.b_end_x;
			fy_s1  <= seg.b_end_y;
			dax_s1 <= DIFW'(seg.a_end_x) - DIFW'(seg.a_start_x);
			day_s1 <= DIFW'(seg.a_end_y) - DIFW'(seg.a_start_y);
			dbx_s1 <= DIFW'(seg.b_end_x) - DIFW'(seg.b_start_x);
			dby_s1 <= DIFW'(seg.b_end_y) - DIFW'(seg.b_start_y);
			ebx_s1 <= DIFW'(seg.b_start_x) - DIFW'(seg.a_end_x);
			eby_s1 <= DIFW'(seg.b_start_y) - DIFW'(seg.a_end_y);
			efx_s1 <= DIFW'(seg.b_end_x) - DIFW'(seg.a_end_x);
			efy_s1 <= DIFW'(seg.b_end_y) - DIFW'(seg.a_end_y);
			fax_s1 <= DIFW'(seg.a_start_x) - DIFW'(seg.b_end_x);
			fay_s1 <= DIFW'(seg.a_start_y) - DIFW'(seg.b_end_y);
			box_s1[0] <= in_box(seg.a_start_x, seg.a_start_y, seg.b_start_x,
				seg.b_start_y, seg.a_end_x, seg.a_end_y);
			box_s1[1] <= in_box(seg.a_start_x, seg.a_start_y, seg.b_end_x,
				seg.b_end_y, seg.a_end_x, seg.a_end_y);
			box_s1[2] <= in_box(seg.b_start_x, seg.b_start_y, seg.a_start_x,
				seg.a_start_y, seg.b_end_x, seg.b_end_y);
			box_s1[3] <= in_box(seg.b_start_x, seg.b_start_y, seg.a_end_x,
				seg.a_end_y, seg.b_end_x, seg.b_end_y);

			p1a_s2 <= PRW'(day_s1) * PRW'(ebx_s1);
			p1b_s2 <= PRW'(dax_s1) * PRW'(eby_s1);
			p2a_s2 <= PRW'(day_s1) * PRW'(efx_s1);
			p2b_s2 <= PRW'(dax_s1) * PRW'(efy_s1);
			p3a_s2 <= PRW'(dby_s1) * PRW'(fax_s1);
			p3b_s2 <= PRW'(dbx_s1) * PRW'(fay_s1);
			p4a_s2 <= PRW'(dbx_s1) * PRW'(efy_s1);
			p4b_s2 <= PRW'(dby_s1) * PRW'(efx_s1);
			pda_s2 <= PRW'(dax_s1) * PRW'(dby_s1);
			pdb_s2 <= PRW'(day_s1) * PRW'(dbx_s1);
			caa_s2 <= (2*CW)'(ax_s1) * (2*CW)'(ey_s1);
			cab_s2 <= (2*CW)'(ay_s1) * (2*CW)'(ex_s1);
			cba_s2 <= (2*CW)'(bx_s1) * (2*CW)'(fy_s1);
			cbb_s2 <= (2*CW)'(by_s1) * (2*CW)'(fx_s1);
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			dax_s2 <= dax_s1;
			day_s2 <= day_s1;
			dbx_s2 <= dbx_s1;
			dby_s2 <= dby_s1;
			box_s2 <= box_s1;

			o1_s3  <= orient_code(OW'(p1a_s2) - OW'(p1b_s2));
			o2_s3  <= orient_code(OW'(p2a_s2) - OW'(p2b_s2));
			o3_s3  <= orient_code(OW'(p3a_s2) - OW'(p3b_s2));
			o4_s3  <= orient_code(OW'(p4a_s2) - OW'(p4b_s2));
			det_s3 <= OW'(pda_s2) - OW'(pdb_s2);
			ca_s3  <= CAW'(caa_s2) - CAW'(cab_s2);
			cb_s3  <= CAW'(cba_s2) - CAW'(cbb_s2);
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			dax_s3 <= dax_s2;
			day_s3 <= day_s2;
			dbx_s3 <= dbx_s2;
			dby_s3 <= dby_s2;
			box_s3 <= box_s2;

			hit_s4 <= ((o1_s3 != o2_s3) && (o3_s3 != o4_s3))
				|| ((o1_s3 == OR_COL) && box_s3[0])
				|| ((o2_s3 == OR_COL) && box_s3[1])
				|| ((o3_s3 == OR_COL) && box_s3[2])
				|| ((o4_s3 == OR_COL) && box_s3[3]);
			nxa_s4 <= NW'(dax_s3) * NW'(cb_s3);
			nxb_s4 <= NW'(ca_s3) * NW'(dbx_s3);
			nya_s4 <= NW'(day_s3) * NW'(cb_s3);
			nyb_s4 <= NW'(ca_s3) * NW'(dby_s3);
			det_s4 <= det_s3;
			ax_s4  <= ax_s3;
			ay_s4  <= ay_s3;

			nx_s5  <= nxa_s4 - nxb_s4;
			ny_s5  <= nya_s4 - nyb_s4;
			det_s5 <= det_s4;
			hit_s5 <= hit_s4;
			ax_s5  <= ax_s4;
			ay_s5  <= ay_s4;

			hit_s6  <= hit_s5;
			par_s6  <= (det_s5 == '0);
			negx_s6 <= nx_s5[NW-1] ^ det_s5[OW-1];
			negy_s6 <= ny_s5[NW-1] ^ det_s5[OW-1];
			mx_s6   <= nx_s5[NW-1] ? NW'(-nx_s5) : NW'(nx_s5);
			my_s6   <= ny_s5[NW-1] ? NW'(-ny_s5) : NW'(ny_s5);
			dm_s6   <= det_s5[OW-1] ? DW'(-det_s5) : DW'(det_s5);
			ax_s6   <= ax_s5;
			ay_s6   <= ay_s5;
		end
	end

	// The high part of the shifted numerator, compared with the divisor,
	// tells whether the quotient needs more than QB bits.
	always_comb begin
		shx      = SW'(mx_s6) << FRAC_BITS;
		shy      = SW'(my_s6) << FRAC_BITS;
		sd0.hit  = hit_s6;
		sd0.par  = par_s6;
		sd0.negx = negx_s6;
		sd0.negy = negy_s6;
		sd0.ovfx = DW'(shx[SW-1:QB]) >= dm_s6;
		sd0.ovfy = DW'(shy[SW-1:QB]) >= dm_s6;
		sd0.ax   = ax_s6;
		sd0.ay   = ay_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else if (en) begin
			dv_s[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].rx <= DW'(shx[SW-1:QB]);
			div_s[0].ry <= DW'(shy[SW-1:QB]);
			div_s[0].lx <= shx[QB-1:0];
			div_s[0].ly <= shy[QB-1:0];
			div_s[0].qx <= '0;
			div_s[0].qy <= '0;
			div_s[0].d  <= dm_s6;
			div_s[0].sd <= sd0;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_div
		logic [DW:0] tx, ty;
		logic        gx, gy;

		always_comb begin
			tx = {div_s[k-1].rx, div_s[k-1].lx[QB-1]};
			ty = {div_s[k-1].ry, div_s[k-1].ly[QB-1]};
			gx = tx >= {1'b0, div_s[k-1].d};
			gy = ty >= {1'b0, div_s[k-1].d};
			nxt[k]    = div_s[k-1];
			nxt[k].rx = gx ? DW'(tx - {1'b0, div_s[k-1].d}) : tx[DW-1:0];
			nxt[k].ry = gy ? DW'(ty - {1'b0, div_s[k-1].d}) : ty[DW-1:0];
			nxt[k].lx = div_s[k-1].lx << 1;
			nxt[k].ly = div_s[k-1].ly << 1;
			nxt[k].qx = {div_s[k-1].qx[QB-2:0], gx};
			nxt[k].qy = {div_s[k-1].qy[QB-2:0], gy};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else if (en) begin
				dv_s[k] <= dv_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= nxt[k];
			end
		end
	end

	always_comb begin
		fin  = div_s[QB];
		satx = fin.sd.ovfx || (fin.qx > (fin.sd.negx ? LIM_NEG : LIM_POS));
		saty = fin.sd.ovfy || (fin.qy > (fin.sd.negy ? LIM_NEG : LIM_POS));
		if (satx) begin
			qpx = fin.sd.negx ? SAT_MIN : SAT_MAX;
		end else begin
			qpx = fin.sd.negx ? -OUT_W'(fin.qx) : OUT_W'(fin.qx);
		end
		if (saty) begin
			qpy = fin.sd.negy ? SAT_MIN : SAT_MAX;
		end else begin
			qpy = fin.sd.negy ? -OUT_W'(fin.qy) : OUT_W'(fin.qy);
		end
	end

	// A start point scaled by at most sixteen fraction bits always fits.
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.intersects <= fin.sd.hit;
			out_q.parallel   <= fin.sd.par;
			if (fin.sd.par) begin
				out_q.point_x   <= OUT_W'(fin.sd.ax) <<< FRAC_BITS;
				out_q.point_y   <= OUT_W'(fin.sd.ay) <<< FRAC_BITS;
				out_q.saturated <= 1'b0;
			end else begin
				out_q.point_x   <= qpx;
				out_q.point_y   <= qpy;
				out_q.saturated <= satx || saty;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/segi_chk.sv -----
// ----------------------------------------------------------------------------
// Segment intersection checker
// Port-level assertions for the segment intersection unit.
// ----------------------------------------------------------------------------
`default_nettype none

module segi_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               seg_ready,
	input wire logic               res_valid,
	input wire logic               res_ready,
	input wire segi_pkg::seg_out_t res
);
	import segi_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res))
		else $error("result word changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> seg_ready)
		else $error("input stalled with an empty output");

	a_par_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.parallel |-> !res.saturated)
		else $error("parallel result flagged as saturated");

	a_sat_ext: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.saturated |-> (res.point_x == SAT_MAX)
			|| (res.point_x == SAT_MIN) || (res.point_y == SAT_MAX)
			|| (res.point_y == SAT_MIN))
		else $error("saturated result holds no limit value");

endmodule

bind segment_intersection_unit segi_chk u_segi_chk (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Segment intersection unit testbench
// Streams segment pairs through the unit under random idling on both sides,
// then with no idling, and compares every result word with a behavioral
// predictor of the orientation test and the fixed-point line intersection.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import segi_pkg::*;

	localparam int FRAC = 8;
	localparam int LIMIT_CYCLES = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic seg_valid = 1'b0;
	logic seg_ready;
	seg_in_t seg = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	seg_out_t res;

	seg_in_t pending_words[$];
	seg_out_t expected_results[$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 6;
	int recv_idle = 69;
	bit stimulus_done = 1'b0;

	segment_intersection_unit #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n), .seg_valid(seg_valid), .seg_ready(seg_ready),
		.seg(seg), .res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always #2 clk = ~clk;

	function automatic orient_t turn_of(longint px, longint py, longint qx, longint qy,
		longint rx, longint ry);
		longint v;
		v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
		if (v == 0) begin
			return OR_COL;
		end
		return (v > 0) ? OR_CW : OR_CCW;
	endfunction

	function automatic bit within_box(longint px, longint py, longint qx, longint qy,
		longint rx, longint ry);
		longint xmx, xmn, ymx, ymn;
		xmx = (px > rx) ? px : rx;
		xmn = (px < rx) ? px : rx;
		ymx = (py > ry) ? py : ry;
		ymn = (py < ry) ? py : ry;
		return qx <= xmx && qx >= xmn && qy <= ymx && qy >= ymn;
	endfunction

	function automatic logic signed [31:0] clip_to_word(logic signed [127:0] v, ref bit sat);
		if (v > 128'sh7fff_ffff) begin
			sat = 1'b1;
			return 32'sh7fff_ffff;
		end
		if (v < -128'sh8000_0000) begin
			sat = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [127:0] trunc_div(logic signed [127:0] n,
		logic signed [127:0] d);
		logic [127:0] q;
		bit neg;
		neg = (n < 0) != (d < 0);
		q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
		return neg ? -$signed(q) : $signed(q);
	endfunction

	function automatic seg_out_t intersect_segments(seg_in_t s);
		seg_out_t r;
		longint ax, ay, ex, ey, bx, by, fx, fy, det, ca, cb;
		orient_t o1, o2, o3, o4;
		logic signed [127:0] nx, ny;
		bit sat;
		ax = s.a_start_x; ay = s.a_start_y; ex = s.a_end_x; ey = s.a_end_y;
		bx = s.b_start_x; by = s.b_start_y; fx = s.b_end_x; fy = s.b_end_y;
		o1 = turn_of(ax, ay, ex, ey, bx, by);
		o2 = turn_of(ax, ay, ex, ey, fx, fy);
		o3 = turn_of(bx, by, fx, fy, ax, ay);
		o4 = turn_of(bx, by, fx, fy, ex, ey);
		r = '0;
		sat = 1'b0;
		r.intersects = (o1 != o2 && o3 != o4)
			|| (o1 == OR_COL && within_box(ax, ay, bx, by, ex, ey))
			|| (o2 == OR_COL && within_box(ax, ay, fx, fy, ex, ey))
			|| (o3 == OR_COL && within_box(bx, by, ax, ay, fx, fy))
			|| (o4 == OR_COL && within_box(bx, by, ex, ey, fx, fy));
		det = (ax - ex) * (by - fy) - (ay - ey) * (bx - fx);
		if (det == 0) begin
			r.parallel = 1'b1;
			r.point_x = clip_to_word(128'(ax) <<< FRAC, sat);
			r.point_y = clip_to_word(128'(ay) <<< FRAC, sat);
		end else begin
			ca = ax * ey - ay * ex;
			cb = bx * fy - by * fx;
			nx = 128'(ca) * 128'(bx - fx) - 128'(ax - ex) * 128'(cb);
			ny = 128'(ca) * 128'(by - fy) - 128'(ay - ey) * 128'(cb);
			r.point_x = clip_to_word(trunc_div(nx <<< FRAC, 128'(det)), sat);
			r.point_y = clip_to_word(trunc_div(ny <<< FRAC, 128'(det)), sat);
		end
		r.saturated = sat;
		return r;
	endfunction

	function automatic logic signed [15:0] pick_coord(int mode);
		case (mode)
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($signed($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string what, seg_out_t got, seg_out_t want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
		end
		if (arst_n && (!seg_valid || seg_ready)) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
				seg_valid <= 1'b1;
				seg <= pending_words.pop_front();
			end else begin
				seg_valid <= 1'b0;
			end
		end
		if (arst_n) begin
			res_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && seg_valid && seg_ready) begin
			expected_results.push_back(intersect_segments(seg));
		end
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected word", res, '0);
			end else begin
				seg_out_t want;
				want = expected_results.pop_front();
				if (res.intersects !== want.intersects) report_mismatch("intersects", res, want);
				if (res.parallel !== want.parallel) report_mismatch("parallel", res, want);
				if (res.point_x !== want.point_x) report_mismatch("point_x", res, want);
				if (res.point_y !== want.point_y) report_mismatch("point_y", res, want);
				if (res.saturated !== want.saturated) report_mismatch("saturated", res, want);
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic queue_word(seg_in_t s);
		pending_words.push_back(s);
	endtask

	// Checked at the falling edge, when the driver and monitor updates have settled.
	task automatic drain;
		while (pending_words.size() > 0 || seg_valid || expected_results.size() > 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		seg_in_t s;
		int k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: extremes, crossing, touching, collinear overlap, degenerate,
		// parallel pairs, some spanning the full coordinate range.
		queue_word('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
			16'sh7fff, 16'sh7fff});
		queue_word('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000});
		queue_word('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
			16'sh7fff, 16'sh8000});
		queue_word('{0, 0, 10, 10, 0, 10, 10, 0});
		queue_word('{0, 0, 10, 0, 10, 0, 10, 10});
		queue_word('{0, 0, 10, 0, 5, 0, 20, 0});
		queue_word('{0, 0, 10, 0, 11, 0, 20, 0});
		queue_word('{0, 0, 10, 0, 0, 1, 10, 1});
		queue_word('{3, 3, 3, 3, 0, 0, 6, 6});
		queue_word('{3, 4, 3, 4, 0, 0, 6, 6});
		queue_word('{5, 5, 5, 5, 5, 5, 5, 5});
		queue_word('{0, 0, 1, 0, 2, 1, 3, 1});
		queue_word('{16'sh8000, 0, 16'sh7fff, 1, 16'sh8000, 1, 16'sh7fff, 2});
		queue_word('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7ffe, 16'sh8000, 16'sh8001,
			16'sh7fff, 16'sh7fff});
		queue_word('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 0, 0, 1, 1});
		queue_word('{-1, -1, -1, 1, -2, 0, 0, 0});
		for (k = 0; k < 2000; k++) begin
			case ($urandom_range(3))
				0: s = '{pick_coord($urandom_range(3)), pick_coord($urandom_range(3)),
					pick_coord($urandom_range(3)), pick_coord($urandom_range(3)),
					pick_coord($urandom_range(3)), pick_coord($urandom_range(3)),
					pick_coord($urandom_range(3)), pick_coord($urandom_range(3))};
				1: begin
					s = '{pick_coord(2), pick_coord(2), pick_coord(2), pick_coord(2),
						pick_coord(2), pick_coord(2), pick_coord(2), pick_coord(2)};
					if ($urandom_range(1)) begin
						s.b_end_x = s.b_start_x + (s.a_end_x - s.a_start_x);
						s.b_end_y = s.b_start_y + (s.a_end_y - s.a_start_y);
					end
				end
				default: s = seg_in_t'({$urandom, $urandom, $urandom, $urandom});
			endcase
			queue_word(s);
			if (k == 700 || k == 1400) begin
				drain();
				if (k == 700) begin
					send_idle = 69;
					recv_idle = 6;
				end else begin
					send_idle = 0;
					recv_idle = 0;
				end
			end
		end
		drain();
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
